// ===== rtl/hcm_pkg.sv =====
package hcm_pkg;

	localparam int PosW   = 13;
	localparam int ZW     = 16;
	localparam int QuadW  = 12;
	localparam int QDepth = 4;
	localparam int QCntW  = $clog2(QDepth + 1);

	typedef logic [PosW-1:0]  pos_t;
	typedef logic [ZW-1:0]    zval_t;
	typedef logic [QuadW-1:0] quad_t;

	// register indexes of the configuration port
	typedef enum logic [1:0] {
		REG_DETAIL_LEVEL = 2'd0,
		REG_CELL_COL     = 2'd1,
		REG_CELL_ROW     = 2'd2,
		REG_UNUSED       = 2'd3
	} reg_idx_t;

	// face of the column being emitted
	typedef enum logic [2:0] {
		FACE_TOP,
		FACE_WEST,
		FACE_EAST,
		FACE_SOUTH,
		FACE_NORTH
	} face_t;

	// shade of a face colour
	typedef enum logic [1:0] {
		SHADE_TOP,
		SHADE_VERT,
		SHADE_HORIZ
	} shade_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// one column, classified and ready for vertex emission
	typedef struct packed {
		pos_t       x0;
		pos_t       x1;
		pos_t       y0;
		pos_t       y1;
		zval_t      top;
		zval_t      west_foot;
		zval_t      south_foot;
		logic       xlast;
		logic       ylast;
		logic [1:0] level;
		quad_t      quad_base;
	} col_desc_t;

	// level colours; vertical walls at 0.8, horizontal walls at 0.7, truncated
	function automatic rgb_t level_colour(input logic [1:0] level, input shade_t shade);
		rgb_t c;
		c = '{r: 8'd40, g: 8'd130, b: 8'd40};
		unique case (level)
			2'd0: begin
				unique case (shade)
					SHADE_VERT:  c = '{r: 8'd32, g: 8'd104, b: 8'd32};
					SHADE_HORIZ: c = '{r: 8'd28, g: 8'd91,  b: 8'd28};
					default:     c = '{r: 8'd40, g: 8'd130, b: 8'd40};
				endcase
			end
			2'd1: begin
				unique case (shade)
					SHADE_VERT:  c = '{r: 8'd104, g: 8'd80,  b: 8'd32};
					SHADE_HORIZ: c = '{r: 8'd91,  g: 8'd70,  b: 8'd28};
					default:     c = '{r: 8'd130, g: 8'd100, b: 8'd40};
				endcase
			end
			2'd2: begin
				unique case (shade)
					SHADE_VERT:  c = '{r: 8'd104, g: 8'd80,  b: 8'd144};
					SHADE_HORIZ: c = '{r: 8'd91,  g: 8'd70,  b: 8'd126};
					default:     c = '{r: 8'd130, g: 8'd100, b: 8'd180};
				endcase
			end
			default: begin
				unique case (shade)
					SHADE_VERT:  c = '{r: 8'd32, g: 8'd120, b: 8'd80};
					SHADE_HORIZ: c = '{r: 8'd28, g: 8'd105, b: 8'd70};
					default:     c = '{r: 8'd40, g: 8'd150, b: 8'd100};
				endcase
			end
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/hcm_ram.sv =====
module hcm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/hcm_fifo.sv =====
module hcm_fifo (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  hcm_pkg::col_desc_t       wdata,
	input  logic                     pop,
	output hcm_pkg::col_desc_t       head,
	output logic                     head_valid,
	output logic [hcm_pkg::QCntW-1:0] count
);
	import hcm_pkg::*;

	localparam int PW = $clog2(QDepth);

	col_desc_t          entry_q [QDepth];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [QCntW-1:0]   count_q;

	assign head       = entry_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign count      = count_q;

	// store incoming descriptors
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= PW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= PW'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= QCntW'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= QCntW'(count_q - 1'b1);
			end
		end
	end

endmodule

// ===== rtl/hcm_front.sv =====
module hcm_front #(
	parameter int GRID_MAX  = 32,
	parameter int CELL_SPAN = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [15:0]        height,
	input  logic               cell_start,
	input  logic [1:0]         detail_level,
	input  logic [6:0]         cell_col,
	input  logic [6:0]         cell_row,
	output logic               desc_push,
	output hcm_pkg::col_desc_t desc
);
	import hcm_pkg::*;

	localparam int AW = $clog2(GRID_MAX);
	localparam int GW = $clog2(GRID_MAX + 1);

	logic [AW-1:0]  col_q;
	logic [AW-1:0]  row_q;
	zval_t          prev_height_q;
	quad_t          quad_q;

	logic [AW-1:0]  x;
	logic [AW-1:0]  y;
	quad_t          qbase;
	logic [GW-1:0]  grid;
	logic [GW-1:0]  grid_m1;
	logic           xlast;
	logic           ylast;
	quad_t          qnext;

	logic           valid_s1;
	logic [AW-1:0]  x_s1;
	logic [AW-1:0]  y_s1;
	zval_t          top_s1;
	zval_t          sfoot_s1;
	logic           xlast_s1;
	logic           ylast_s1;
	logic [1:0]     level_s1;
	quad_t          qbase_s1;
	logic           fwd_s1;
	zval_t          fwd_top_s1;

	zval_t          prev_row_rdata;
	pos_t           step;
	pos_t           x0;
	pos_t           y0;

	// classify the incoming column
	always_comb begin
		x       = cell_start ? '0 : col_q;
		y       = cell_start ? '0 : row_q;
		qbase   = cell_start ? '0 : quad_q;
		grid    = GW'(GRID_MAX) >> detail_level;
		if (grid == '0) begin
			grid = GW'(1);
		end
		grid_m1 = GW'(grid - 1'b1);
		xlast   = (GW'(x) >= grid_m1);
		ylast   = (GW'(y) >= grid_m1);
		qnext   = QuadW'(qbase + QuadW'(3) + QuadW'(xlast) + QuadW'(ylast));
	end

	// advance position counters, previous height and quad counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q         <= '0;
			row_q         <= '0;
			prev_height_q <= '0;
			quad_q        <= '0;
		end else if (accept) begin
			prev_height_q <= height;
			if (ylast) begin
				row_q <= '0;
				if (xlast) begin
					col_q  <= '0;
					quad_q <= '0;
				end else begin
					col_q  <= AW'(x + 1'b1);
					quad_q <= qnext;
				end
			end else begin
				row_q  <= AW'(y + 1'b1);
				col_q  <= x;
				quad_q <= qnext;
			end
		end
	end

	// hold the column while the previous row's height is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// register the column and forward the height written to the entry read
	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1       <= x;
			y_s1       <= y;
			top_s1     <= height;
			sfoot_s1   <= (y != '0) ? prev_height_q : '0;
			xlast_s1   <= xlast;
			ylast_s1   <= ylast;
			level_s1   <= detail_level;
			qbase_s1   <= qbase;
			fwd_s1     <= valid_s1 && (y_s1 == y);
			fwd_top_s1 <= top_s1;
		end
	end

	// line store of the previous x row
	hcm_ram #(
		.WIDTH (ZW),
		.DEPTH (GRID_MAX)
	) u_prev_row (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (y_s1),
		.wdata (top_s1),
		.re    (accept),
		.raddr (y),
		.rdata (prev_row_rdata)
	);

	// build the descriptor for the back end
	always_comb begin
		step = PosW'(1) << level_s1;
		x0   = PosW'(cell_col * CELL_SPAN) + (PosW'(x_s1) << level_s1);
		y0   = PosW'(cell_row * CELL_SPAN) + (PosW'(y_s1) << level_s1);
		desc.x0         = x0;
		desc.x1         = PosW'(x0 + step);
		desc.y0         = y0;
		desc.y1         = PosW'(y0 + step);
		desc.top        = top_s1;
		desc.west_foot  = (x_s1 != '0) ? (fwd_s1 ? fwd_top_s1 : prev_row_rdata) : '0;
		desc.south_foot = sfoot_s1;
		desc.xlast      = xlast_s1;
		desc.ylast      = ylast_s1;
		desc.level      = level_s1;
		desc.quad_base  = qbase_s1;
	end

	assign desc_push = valid_s1;

endmodule

// ===== rtl/hcm_back.sv =====
module hcm_back (
	input  logic               clk,
	input  logic               arst_n,
	input  hcm_pkg::col_desc_t head,
	input  logic               head_valid,
	output logic               head_pop,
	input  logic               pop,
	output logic               empty,
	output logic [12:0]        pos_x,
	output logic [12:0]        pos_y,
	output logic [15:0]        pos_z,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic [7:0]         alpha,
	output logic [11:0]        quad_index,
	output logic               last,
	output logic               cell_done
);
	import hcm_pkg::*;

	typedef enum logic [1:0] {
		Z_TOP,
		Z_WEST,
		Z_SOUTH,
		Z_ZERO
	} zsel_t;

	face_t        face_q;
	face_t        face_next;
	logic [1:0]   corner_q;
	logic         out_valid_q;
	logic         advance;
	logic         item_end;

	logic         use_x1;
	logic         use_y1;
	zsel_t        zsel;
	shade_t       shade;
	logic [2:0]   qoff;
	rgb_t         colour;
	zval_t        z;

	assign advance  = head_valid && (!out_valid_q || pop);
	assign item_end = (corner_q == 2'd3) &&
		((face_q == FACE_NORTH) || ((face_q == FACE_SOUTH) && !head.ylast));
	assign head_pop = advance && item_end;
	assign empty    = !out_valid_q;

	// next face after the fourth corner
	always_comb begin
		face_next = face_q;
		if (corner_q == 2'd3) begin
			unique case (face_q)
				FACE_TOP:   face_next = FACE_WEST;
				FACE_WEST:  face_next = head.xlast ? FACE_EAST : FACE_SOUTH;
				FACE_EAST:  face_next = FACE_SOUTH;
				FACE_SOUTH: face_next = head.ylast ? FACE_NORTH : FACE_TOP;
				default:    face_next = FACE_TOP;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_q   <= FACE_TOP;
			corner_q <= '0;
		end else if (advance) begin
			face_q   <= face_next;
			corner_q <= 2'(corner_q + 1'b1);
		end
	end

	// corner selection for the current face
	always_comb begin
		use_x1 = 1'b0;
		use_y1 = 1'b0;
		zsel   = Z_TOP;
		shade  = SHADE_TOP;
		qoff   = 3'd0;
		unique case (face_q)
			FACE_TOP: begin
				use_x1 = (corner_q == 2'd1) || (corner_q == 2'd2);
				use_y1 = corner_q[1];
				zsel   = Z_TOP;
				shade  = SHADE_TOP;
				qoff   = 3'd0;
			end
			FACE_WEST: begin
				use_x1 = 1'b0;
				use_y1 = (corner_q == 2'd1) || (corner_q == 2'd2);
				zsel   = corner_q[1] ? Z_WEST : Z_TOP;
				shade  = SHADE_VERT;
				qoff   = 3'd1;
			end
			FACE_EAST: begin
				use_x1 = 1'b1;
				use_y1 = (corner_q == 2'd1) || (corner_q == 2'd2);
				zsel   = corner_q[1] ? Z_TOP : Z_ZERO;
				shade  = SHADE_VERT;
				qoff   = 3'd2;
			end
			FACE_SOUTH: begin
				use_x1 = (corner_q == 2'd1) || (corner_q == 2'd2);
				use_y1 = 1'b0;
				zsel   = corner_q[1] ? Z_TOP : Z_SOUTH;
				shade  = SHADE_HORIZ;
				qoff   = 3'(2 + head.xlast);
			end
			default: begin
				use_x1 = (corner_q == 2'd1) || (corner_q == 2'd2);
				use_y1 = 1'b1;
				zsel   = corner_q[1] ? Z_ZERO : Z_TOP;
				shade  = SHADE_HORIZ;
				qoff   = 3'(3 + head.xlast);
			end
		endcase
		unique case (zsel)
			Z_TOP:   z = head.top;
			Z_WEST:  z = head.west_foot;
			Z_SOUTH: z = head.south_foot;
			default: z = '0;
		endcase
		colour = level_colour(head.level, shade);
	end

	// output register: hold the vertex until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pos_x      <= use_x1 ? head.x1 : head.x0;
			pos_y      <= use_y1 ? head.y1 : head.y0;
			pos_z      <= z;
			red        <= colour.r;
			green      <= colour.g;
			blue       <= colour.b;
			alpha      <= 8'd255;
			quad_index <= QuadW'(head.quad_base + QuadW'(qoff));
			last       <= item_end;
			cell_done  <= item_end && head.xlast && head.ylast;
		end
	end

endmodule

// ===== rtl/heightmap_column_mesher.sv =====
// Heightmap column mesher.
// Input queue side: present height and cell_start with push; the item transfers
// on a rising edge where push is high and full is low. Columns arrive x-major,
// y inner; cell_start restarts the position and quad counters at zero.
// Result queue side: while empty is low the oldest vertex sits on pos_x .. cell_done;
// it transfers on an edge where pop is high. last marks the final vertex of a
// column, cell_done the final vertex of the cell.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 detail level,
// 1 cell column, 2 cell row); write only while the block is idle.
// A column passes the read-stage registers, the descriptor queue and the output
// register before its first vertex appears. Throughput: one vertex per cycle while
// pop is high and a descriptor waits, set by the single-vertex output register. A
// four-entry descriptor queue between the classifier and the vertex generator lets
// new columns transfer while vertices are still being emitted or the receiver stalls;
// a stalled receiver holds the current vertex and the queue fills until full rises.
// Reset clears counters, queue and output valid; the previous-row line store is not
// cleared; in a one-level cell begun by cell_start it is written before it is read.
module heightmap_column_mesher #(
	parameter int GRID_MAX  = 32,
	parameter int CELL_SPAN = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] height,
	input  logic        cell_start,
	output logic        empty,
	input  logic        pop,
	output logic [12:0] pos_x,
	output logic [12:0] pos_y,
	output logic [15:0] pos_z,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic [11:0] quad_index,
	output logic        last,
	output logic        cell_done,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	import hcm_pkg::*;

	logic [1:0]       detail_level_q;
	logic [6:0]       cell_col_q;
	logic [6:0]       cell_row_q;

	logic             accept;
	logic             desc_push;
	col_desc_t        desc;
	col_desc_t        head;
	logic             head_valid;
	logic             head_pop;
	logic [QCntW-1:0] q_count;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detail_level_q <= '0;
			cell_col_q     <= '0;
			cell_row_q     <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DETAIL_LEVEL: detail_level_q <= cfg_data[1:0];
				REG_CELL_COL:     cell_col_q     <= cfg_data;
				REG_CELL_ROW:     cell_row_q     <= cfg_data;
				default:          ;
			endcase
		end
	end

	// count the descriptor still in the read stage against the queue space
	assign full   = ((QCntW + 1)'(q_count) + (QCntW + 1)'(desc_push)) >= (QCntW + 1)'(QDepth);
	assign accept = push && !full;

	hcm_front #(
		.GRID_MAX  (GRID_MAX),
		.CELL_SPAN (CELL_SPAN)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.height       (height),
		.cell_start   (cell_start),
		.detail_level (detail_level_q),
		.cell_col     (cell_col_q),
		.cell_row     (cell_row_q),
		.desc_push    (desc_push),
		.desc         (desc)
	);

	hcm_fifo u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (desc_push),
		.wdata      (desc),
		.pop        (head_pop),
		.head       (head),
		.head_valid (head_valid),
		.count      (q_count)
	);

	hcm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.pop        (pop),
		.empty      (empty),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.alpha      (alpha),
		.quad_index (quad_index),
		.last       (last),
		.cell_done  (cell_done)
	);

endmodule

// ===== bench/tb_heightmap_column_mesher.sv =====
`timescale 1ns / 100ps

module tb_heightmap_column_mesher;
	import hcm_pkg::*;

	localparam int CycleLimit = 400000;
	localparam int ItemTarget = 310;
	localparam int DrainCycles = 20;

	// one vertex as the block should present it
	typedef struct packed {
		pos_t       x;
		pos_t       y;
		zval_t      z;
		rgb_t       c;
		quad_t      quad;
		logic       fin;
		logic       done;
	} exp_vert_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [15:0] height = 16'd0;
	logic        cell_start = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [12:0] pos_x;
	logic [12:0] pos_y;
	logic [15:0] pos_z;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic [11:0] quad_index;
	logic        last;
	logic        cell_done;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_DETAIL_LEVEL;
	logic [6:0]  cfg_data = 7'd0;

	// mesher state as the bench expects it
	logic [1:0]  lvl = 2'd0;
	logic [6:0]  cell_x = 7'd0;
	logic [6:0]  cell_y = 7'd0;
	logic [5:0]  col_cnt = 6'd0;
	logic [5:0]  row_cnt = 6'd0;
	logic [15:0] row_heights [32];
	logic [15:0] south_height = 16'd0;
	quad_t       quad_cnt = '0;

	exp_vert_t   pending_vertices[$];
	exp_vert_t   want_v;
	int          errors = 0;
	int          columns_sent = 0;
	int          vertices_checked = 0;
	int          cells_seen = 0;
	int          cycles = 0;
	int          push_idle_pct = 28;
	int          pop_idle_pct = 28;

	heightmap_column_mesher u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.height     (height),
		.cell_start (cell_start),
		.empty      (empty),
		.pop        (pop),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.alpha      (alpha),
		.quad_index (quad_index),
		.last       (last),
		.cell_done  (cell_done),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #1 clk = ~clk;

	// base colour of each detail level
	function automatic rgb_t level_base(input logic [1:0] level);
		case (level)
			2'd0:    return '{r: 8'd40,  g: 8'd130, b: 8'd40};
			2'd1:    return '{r: 8'd130, g: 8'd100, b: 8'd40};
			2'd2:    return '{r: 8'd130, g: 8'd100, b: 8'd180};
			default: return '{r: 8'd40,  g: 8'd150, b: 8'd100};
		endcase
	endfunction

	// scale each component by tenths, truncating
	function automatic rgb_t shaded(input rgb_t c, input int unsigned tenths);
		rgb_t s;
		s.r = 8'(int'(c.r) * tenths / 10);
		s.g = 8'(int'(c.g) * tenths / 10);
		s.b = 8'(int'(c.b) * tenths / 10);
		return s;
	endfunction

	function automatic void add_vertex(input int unsigned vx, input int unsigned vy,
			input logic [15:0] vz, input rgb_t c, input logic fin, input logic done);
		exp_vert_t v;
		v.x = pos_t'(vx);
		v.y = pos_t'(vy);
		v.z = vz;
		v.c = c;
		v.quad = quad_cnt;
		v.fin = fin;
		v.done = fin & done;
		pending_vertices = {pending_vertices, v};
	endfunction

	// expand one column into its vertices and advance the mesher state
	function automatic void mesh_column(input logic [15:0] h, input logic restart);
		int unsigned grid, stride, x, y, x0, x1, y0, y1;
		logic xl, yl;
		logic [15:0] foot;
		rgb_t ct, cv, ch;
		if (restart) begin
			col_cnt = '0;
			row_cnt = '0;
			quad_cnt = '0;
		end
		grid = 32 >> lvl;
		stride = 1 << lvl;
		x = col_cnt;
		y = row_cnt;
		xl = (x >= grid - 1);
		yl = (y >= grid - 1);
		ct = level_base(lvl);
		cv = shaded(ct, 8);
		ch = shaded(ct, 7);
		x0 = cell_x * 32 + x * stride;
		x1 = x0 + stride;
		y0 = cell_y * 32 + y * stride;
		y1 = y0 + stride;

		// top quad
		add_vertex(x0, y0, h, ct, 1'b0, 1'b0);
		add_vertex(x1, y0, h, ct, 1'b0, 1'b0);
		add_vertex(x1, y1, h, ct, 1'b0, 1'b0);
		add_vertex(x0, y1, h, ct, 1'b0, 1'b0);
		quad_cnt++;

		// west wall down to the previous row, or to the ground on the first row
		foot = (x != 0 && y < 32) ? row_heights[y] : 16'd0;
		add_vertex(x0, y0, h, cv, 1'b0, 1'b0);
		add_vertex(x0, y1, h, cv, 1'b0, 1'b0);
		add_vertex(x0, y1, foot, cv, 1'b0, 1'b0);
		add_vertex(x0, y0, foot, cv, 1'b0, 1'b0);
		quad_cnt++;

		if (xl) begin
			add_vertex(x1, y0, 16'd0, cv, 1'b0, 1'b0);
			add_vertex(x1, y1, 16'd0, cv, 1'b0, 1'b0);
			add_vertex(x1, y1, h, cv, 1'b0, 1'b0);
			add_vertex(x1, y0, h, cv, 1'b0, 1'b0);
			quad_cnt++;
		end

		// south wall down to the previous column of this row
		foot = (y != 0) ? south_height : 16'd0;
		add_vertex(x0, y0, foot, ch, 1'b0, 1'b0);
		add_vertex(x1, y0, foot, ch, 1'b0, 1'b0);
		add_vertex(x1, y0, h, ch, 1'b0, 1'b0);
		add_vertex(x0, y0, h, ch, !yl, 1'b0);
		quad_cnt++;

		if (yl) begin
			add_vertex(x0, y1, h, ch, 1'b0, 1'b0);
			add_vertex(x1, y1, h, ch, 1'b0, 1'b0);
			add_vertex(x1, y1, 16'd0, ch, 1'b0, 1'b0);
			add_vertex(x0, y1, 16'd0, ch, 1'b1, xl);
			quad_cnt++;
		end

		// record the heights and advance position counters
		if (y < 32) row_heights[y] = h;
		south_height = h;
		if (yl) begin
			row_cnt = '0;
			if (xl) begin
				col_cnt = '0;
				quad_cnt = '0;
			end else begin
				col_cnt = 6'(x + 1);
			end
		end else begin
			row_cnt = 6'(y + 1);
		end
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// compare each vertex transfer with the oldest expectation; drive pop
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_vertices.size() == 0) begin
				$display("%0t: vertex transfer with nothing expected, got x %0d y %0d z %0d",
					$time, pos_x, pos_y, pos_z);
				errors++;
			end else begin
				want_v = pending_vertices.pop_front();
				check_field("pos_x", want_v.x, pos_x);
				check_field("pos_y", want_v.y, pos_y);
				check_field("pos_z", want_v.z, pos_z);
				check_field("red", want_v.c.r, red);
				check_field("green", want_v.c.g, green);
				check_field("blue", want_v.c.b, blue);
				check_field("alpha", 16'd255, alpha);
				check_field("quad_index", want_v.quad, quad_index);
				check_field("last", want_v.fin, last);
				check_field("cell_done", want_v.done, cell_done);
				vertices_checked++;
				if (want_v.done) cells_seen++;
			end
		end
		pop <= ($urandom_range(99) >= pop_idle_pct);
	end

	// stop a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("%0t: timeout with %0d vertices outstanding", $time,
				pending_vertices.size());
			$display("FAIL heightmap_column_mesher");
			$finish;
		end
	end

	// write all three registers back to back; only while idle
	task automatic set_cell(input logic [1:0] level, input logic [6:0] cx,
			input logic [6:0] cy);
		cfg_we <= 1'b1;
		cfg_index <= REG_DETAIL_LEVEL;
		cfg_data <= {5'd0, level};
		@(posedge clk);
		cfg_index <= REG_CELL_COL;
		cfg_data <= cx;
		@(posedge clk);
		cfg_index <= REG_CELL_ROW;
		cfg_data <= cy;
		@(posedge clk);
		cfg_we <= 1'b0;
		lvl = level;
		cell_x = cx;
		cell_y = cy;
		@(posedge clk);
	endtask

	// offer one column and hold it until it transfers; push stays high afterwards
	task automatic send_column(input logic [15:0] h, input logic restart);
		while ($urandom_range(99) < push_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		height <= h;
		cell_start <= restart;
		do @(posedge clk); while (full);
		mesh_column(h, restart);
		columns_sent++;
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (pending_vertices.size() != 0) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_height();
		case ($urandom_range(9))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [6:0] pick_coord();
		case ($urandom_range(9))
			0:       return 7'd0;
			1:       return 7'd127;
			default: return 7'($urandom);
		endcase
	endfunction

	// a run of columns; noise_pct sprinkles stray restarts through it
	task automatic send_columns(input int n, input logic restart, input int noise_pct);
		for (int i = 0; i < n; i++)
			send_column(pick_height(), (i == 0) ? restart : ($urandom_range(99) < noise_pct));
		wait_drained();
	endtask

	// whole smallest cell at the far corner, then one more column past its end
	task automatic test_cell_edges();
		logic [15:0] h;
		set_cell(2'd3, 7'd127, 7'd127);
		for (int i = 0; i < 17; i++) begin
			case (i % 4)
				0:       h = 16'h0000;
				1:       h = 16'hFFFF;
				2:       h = 16'h5A5A;
				default: h = 16'hA5A5;
			endcase
			send_column(h, i == 0);
		end
		wait_drained();
	endtask

	// colours and strides of the remaining levels
	task automatic test_level_colours();
		for (int l = 0; l < 3; l++) begin
			set_cell(2'(l), 7'(l * 40), 7'(127 - l * 40));
			send_column(16'hFFFF, 1'b1);
			send_column(16'h0000, 1'b0);
			wait_drained();
		end
	endtask

	// full first row at the finest level, back to back, so every line store entry is written
	task automatic test_line_store_fill();
		push_idle_pct = 0;
		pop_idle_pct = 0;
		set_cell(2'd0, pick_coord(), pick_coord());
		send_columns(40, 1'b1, 0);
		push_idle_pct = 28;
		pop_idle_pct = 28;
	endtask

	// coarsen the level part way through a cell so both counters overrun the grid
	task automatic test_level_change_in_cell();
		logic [6:0] cx, cy;
		cx = pick_coord();
		cy = pick_coord();
		set_cell(2'd1, cx, cy);
		send_columns(74, 1'b1, 0);
		set_cell(2'd3, cx, cy);
		send_columns(6, 1'b0, 0);
	endtask

	// random cells, mostly well formed, some continuing across a level change
	task automatic test_random_cells();
		logic [1:0] level;
		int n;
		while (columns_sent < ItemTarget) begin
			level = 2'($urandom_range(3));
			set_cell(level, pick_coord(), pick_coord());
			case (level)
				2'd3:    n = $urandom_range(8, 40);
				2'd2:    n = $urandom_range(10, 70);
				default: n = $urandom_range(10, 50);
			endcase
			send_columns(n, $urandom_range(99) >= 20, 4);
		end
	endtask

	initial begin
		for (int i = 0; i < 32; i++) row_heights[i] = 16'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_cell_edges();
		test_level_colours();
		test_line_store_fill();
		test_level_change_in_cell();
		test_random_cells();
		wait_drained();
		repeat (DrainCycles) @(posedge clk);
		if (pending_vertices.size() != 0) begin
			$display("%0t: %0d vertices never arrived", $time, pending_vertices.size());
			errors++;
		end
		$display("Meshed %0d columns over all four detail levels, %0d vertices compared,",
			columns_sent, vertices_checked);
		$display("%0d cell ends seen, %0d mismatches", cells_seen, errors);
		if (errors == 0) begin
			$display("PASS heightmap_column_mesher");
		end else begin
			$display("FAIL heightmap_column_mesher");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/hcm_pkg.sv
rtl/hcm_ram.sv
rtl/hcm_fifo.sv
rtl/hcm_front.sv
rtl/hcm_back.sv
rtl/heightmap_column_mesher.sv
bench/tb_heightmap_column_mesher.sv
